// ----- rtl/escape_sequence_unescaper_core_macros.svh -----
// Assertion macros for the RTL file that checks its own logic.
`ifndef ESCAPE_SEQUENCE_UNESCAPER_CORE_MACROS_SVH
`define ESCAPE_SEQUENCE_UNESCAPER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ESU_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ESU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/esu_pkg.sv -----
package esu_pkg;

	// Width of the reported length field and default counter width.
	localparam int TOTAL_W          = 16;
	localparam int LENGTH_BITS_DEF  = 16;

	// Characters that steer the scanner. An escaped double quote, like any
	// other unlisted character, decodes to itself.
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_ZERO   = 8'h30;

	// Decoded control characters.
	localparam logic [7:0] CODE_LF   = 8'h0A;
	localparam logic [7:0] CODE_CR   = 8'h0D;
	localparam logic [7:0] CODE_TAB  = 8'h09;

	// An octal escape ends after this many digits.
	localparam int OCT_MAX_DIGITS   = 3;

	// Output queue geometry.
	localparam int OUT_DEPTH        = 4;
	localparam int OUT_PTR_W        = $clog2(OUT_DEPTH);
	localparam int OUT_FILL_W       = OUT_PTR_W + 1;

	// Scanner modes, one-hot.
	typedef enum logic [2:0] {
		MODE_TEXT = 3'b001,
		MODE_ESC  = 3'b010,
		MODE_OCT  = 3'b100
	} mode_t;

	// Scanner state apart from the length counter.
	typedef struct packed {
		mode_t       mode;
		logic [7:0]  oval;
		logic [1:0]  odig;
	} scan_t;

	// One result transaction.
	typedef struct packed {
		logic [7:0]         out_byte;
		logic               byte_valid;
		logic               end_of_string;
		logic [TOTAL_W-1:0] total_length;
	} result_t;

endpackage

// ----- rtl/esu_in_if.sv -----
interface esu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       is_last;

	modport source (output valid, output in_byte, output is_last, input ready);
	modport sink (input valid, input in_byte, input is_last, output ready);
endinterface

// ----- rtl/esu_out_if.sv -----
interface esu_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        byte_valid;
	logic        end_of_string;
	logic [15:0] total_length;

	modport source (output valid, output out_byte, output byte_valid,
		output end_of_string, output total_length, input ready);
	modport sink (input valid, input out_byte, input byte_valid,
		input end_of_string, input total_length, output ready);
endinterface

// ----- rtl/escape_sequence_unescaper_core.sv -----
// Channel   Modport  Direction  Payload
// ingress   sink     in         in_byte[7:0], is_last
// egress    source   out        out_byte[7:0], byte_valid, end_of_string, total_length[15:0]
//
// One byte is accepted per cycle while ingress.ready is high; its zero, one or two results land in a four-entry
// output queue in the same edge and leave from the queue head one per cycle while egress.ready is high.
// An octal flush that yields two results takes two queue entries.
// ingress.ready is high while the queue has room for two results.
// arst_n clears the scanner state, the length counter and the queue pointers.
// A stall on egress fills the queue and then holds ingress off.
module escape_sequence_unescaper_core #(
	parameter int LENGTH_BITS = esu_pkg::LENGTH_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	esu_in_if.sink           ingress,
	esu_out_if.source        egress
);
	import esu_pkg::*;

`include "escape_sequence_unescaper_core_macros.svh"

	scan_t                  scan_q;
	logic [LENGTH_BITS-1:0] cnt_q;
	scan_t                  scan_nxt;
	logic [LENGTH_BITS-1:0] cnt_nxt;
	logic [1:0]             n_res;
	result_t                res0, res1, head;
	logic [OUT_FILL_W-1:0]  fill;
	logic                   acc, pop;
	logic [1:0]             push_n;

	// Handshakes.
	assign ingress.ready = (fill <= OUT_FILL_W'(OUT_DEPTH - 2));
	assign acc           = ingress.valid && ingress.ready;
	assign egress.valid  = (fill != '0);
	assign pop           = egress.valid && egress.ready;
	assign push_n        = acc ? n_res : 2'd0;

	// Decode of the accepted byte against the current scanner state.
	esu_decode #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_decode (
		.cur     (scan_q),
		.cnt     (cnt_q),
		.in_byte (ingress.in_byte),
		.is_last (ingress.is_last),
		.nxt     (scan_nxt),
		.cnt_nxt (cnt_nxt),
		.n_res   (n_res),
		.res0    (res0),
		.res1    (res1)
	);

	// Scanner state advances on every accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q.mode <= MODE_TEXT;
			scan_q.oval <= 8'd0;
			scan_q.odig <= 2'd0;
			cnt_q       <= '0;
		end else if (acc) begin
			scan_q <= scan_nxt;
			cnt_q  <= cnt_nxt;
		end
	end

	// Result queue.
	esu_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push_n (push_n),
		.d0     (res0),
		.d1     (res1),
		.pop    (pop),
		.head   (head),
		.fill   (fill)
	);

	assign egress.out_byte      = head.out_byte;
	assign egress.byte_valid    = head.byte_valid;
	assign egress.end_of_string = head.end_of_string;
	assign egress.total_length  = head.total_length;

	// Checks.
	`ESU_ASSERT_SAME(a_fill_bound, clk, arst_n, 1'b1, fill <= OUT_FILL_W'(OUT_DEPTH), "queue overflow")
	`ESU_ASSERT_SAME(a_last_has_result, clk, arst_n, acc && ingress.is_last, n_res != 2'd0, "last byte without result")
	`ESU_ASSERT_NEXT(a_end_clears, clk, arst_n, acc && ingress.is_last, scan_q.mode == MODE_TEXT && cnt_q == '0, "state not cleared after end")
	`ESU_ASSERT_NEXT(a_idle_hold, clk, arst_n, !acc && !pop, $stable(fill), "queue level moved while idle")

endmodule

// ----- rtl/esu_decode.sv -----
module esu_decode #(
	parameter int LENGTH_BITS = esu_pkg::LENGTH_BITS_DEF
) (
	input  esu_pkg::scan_t   cur,
	input  logic [LENGTH_BITS-1:0] cnt,
	input  logic [7:0]       in_byte,
	input  logic             is_last,
	output esu_pkg::scan_t   nxt,
	output logic [LENGTH_BITS-1:0] cnt_nxt,
	output logic [1:0]       n_res,
	output esu_pkg::result_t res0,
	output esu_pkg::result_t res1
);
	import esu_pkg::*;

	localparam int EXT_W = (LENGTH_BITS > TOTAL_W) ? LENGTH_BITS : TOTAL_W;
	localparam logic [LENGTH_BITS-1:0] CNT_MAX = {LENGTH_BITS{1'b1}};

	// Report the counter modulo 2^16, zero-extended when it is narrower.
	function automatic logic [TOTAL_W-1:0] to_total(input logic [LENGTH_BITS-1:0] c);
		logic [EXT_W-1:0] e;
		e = EXT_W'(c);
		return e[TOTAL_W-1:0];
	endfunction

	logic                   is_oct;
	logic [2:0]             digit;
	logic [7:0]             oval_shift;
	logic                   e0_v, e1_v, flush_v;
	logic [7:0]             e0_b, e1_b;
	scan_t                  mid;
	logic [7:0]             s0_b;
	logic                   s0_v;
	logic [LENGTH_BITS-1:0] cnt1, cnt2;

	assign is_oct     = (in_byte[7:3] == CH_ZERO[7:3]);
	assign digit      = in_byte[2:0];
	assign oval_shift = {cur.oval[4:0], digit};

	// Byte handling per mode: up to two emitted bytes and the next scanner state.
	always_comb begin
		e0_v = 1'b0;
		e0_b = in_byte;
		e1_v = 1'b0;
		e1_b = in_byte;
		mid  = cur;
		case (cur.mode)
			MODE_ESC: begin
				mid.mode = MODE_TEXT;
				if (in_byte == CH_N) begin
					e0_v = 1'b1;
					e0_b = CODE_LF;
				end else if (in_byte == CH_R) begin
					e0_v = 1'b1;
					e0_b = CODE_CR;
				end else if (in_byte == CH_T) begin
					e0_v = 1'b1;
					e0_b = CODE_TAB;
				end else if (is_oct) begin
					mid.mode = MODE_OCT;
					mid.oval = {5'd0, digit};
					mid.odig = 2'd1;
				end else begin
					e0_v = 1'b1;
				end
			end
			MODE_OCT: begin
				if (is_oct) begin
					if (cur.odig == 2'(OCT_MAX_DIGITS - 1)) begin
						e0_v     = 1'b1;
						e0_b     = oval_shift;
						mid.mode = MODE_TEXT;
						mid.oval = 8'd0;
						mid.odig = 2'd0;
					end else begin
						mid.oval = oval_shift;
						mid.odig = cur.odig + 2'd1;
					end
				end else begin
					// Flush the pending value, then treat the byte as plain text.
					e0_v     = 1'b1;
					e0_b     = cur.oval;
					mid.oval = 8'd0;
					mid.odig = 2'd0;
					if (in_byte == CH_BSLASH) begin
						mid.mode = MODE_ESC;
					end else begin
						mid.mode = MODE_TEXT;
						e1_v     = 1'b1;
					end
				end
			end
			default: begin
				if (in_byte == CH_BSLASH) begin
					mid.mode = MODE_ESC;
				end else begin
					mid.mode = MODE_TEXT;
					e0_v     = 1'b1;
				end
			end
		endcase
	end

	// A string that ends inside an octal escape emits the pending value. That
	// case never coincides with another emitted byte.
	assign flush_v = is_last && (mid.mode == MODE_OCT);
	assign s0_v    = e0_v || flush_v;
	assign s0_b    = e0_v ? e0_b : mid.oval;

	// Saturating length after the first and the second emitted byte.
	assign cnt1 = (cnt == CNT_MAX) ? cnt : cnt + LENGTH_BITS'(1);
	assign cnt2 = (cnt1 == CNT_MAX) ? cnt1 : cnt1 + LENGTH_BITS'(1);

	// Result slots, end marker and next state.
	always_comb begin
		res0.out_byte      = s0_v ? s0_b : 8'd0;
		res0.byte_valid    = s0_v;
		res0.end_of_string = is_last && !e1_v;
		res0.total_length  = s0_v ? to_total(cnt1) : to_total(cnt);
		res1.out_byte      = e1_b;
		res1.byte_valid    = 1'b1;
		res1.end_of_string = is_last;
		res1.total_length  = to_total(cnt2);
		if (e1_v) begin
			n_res = 2'd2;
		end else if (s0_v || is_last) begin
			n_res = 2'd1;
		end else begin
			n_res = 2'd0;
		end
		if (is_last) begin
			nxt.mode = MODE_TEXT;
			nxt.oval = 8'd0;
			nxt.odig = 2'd0;
			cnt_nxt  = '0;
		end else begin
			nxt     = mid;
			cnt_nxt = e1_v ? cnt2 : (s0_v ? cnt1 : cnt);
		end
	end

endmodule

// ----- rtl/esu_outq.sv -----
module esu_outq (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [1:0]                      push_n,
	input  esu_pkg::result_t                d0,
	input  esu_pkg::result_t                d1,
	input  logic                            pop,
	output esu_pkg::result_t                head,
	output logic [esu_pkg::OUT_FILL_W-1:0]  fill
);
	import esu_pkg::*;

	result_t                mem_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0]   wr_q;
	logic [OUT_PTR_W-1:0]   rd_q;
	logic [OUT_FILL_W-1:0]  fill_q;

	// Entry storage: up to two results are written per cycle.
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= d0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_q + OUT_PTR_W'(1)] <= d1;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			wr_q   <= wr_q + OUT_PTR_W'(push_n);
			rd_q   <= rd_q + OUT_PTR_W'(pop);
			fill_q <= fill_q + OUT_FILL_W'(push_n) - OUT_FILL_W'(pop);
		end
	end

	assign head = mem_q[rd_q];
	assign fill = fill_q;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;
	import esu_pkg::*;

	localparam int LEN_BITS = LENGTH_BITS_DEF;
	localparam int CYCLE_LIMIT = 600000;
	localparam int MAX_REPORTS = 40;
	localparam int RANDOM_ITEMS = 470;
	localparam int LONG_ITEMS = 40;

	// Characters that the stimulus uses but the package does not name.
	localparam logic [7:0] CH_SEVEN = CH_ZERO + 8'd7;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_EIGHT = CH_ZERO + 8'd8;

	logic clk;
	logic arst_n;

	esu_in_if in_ch ();
	esu_out_if out_ch ();

	escape_sequence_unescaper_core #(
		.LENGTH_BITS(LEN_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.ingress(in_ch),
		.egress(out_ch)
	);

	// Decoder state mirrored by the predictor.
	mode_t scan_mode;
	logic [7:0] oct_val;
	logic [1:0] oct_cnt;
	logic [LEN_BITS-1:0] unescaped_len;

	// Decoded bytes still owed by the block, oldest first.
	result_t decoded_q[$];
	result_t step_res[$];

	int fail_cnt;
	int bytes_sent;
	int cycle_cnt;
	bit src_idle_on;
	bit sink_idle_on;
	int stall_left;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog on the total run length.
	initial begin
		cycle_cnt = 0;
		forever begin
			@(posedge clk);
			cycle_cnt++;
			if (cycle_cnt >= CYCLE_LIMIT) begin
				$display("tb: FAIL");
				$finish;
			end
		end
	end

	// Egress ready with random stall bursts.
	initial begin
		out_ch.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 10);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	function automatic bit is_octal(logic [7:0] b);
		return b >= CH_ZERO && b <= CH_SEVEN;
	endfunction

	function automatic void clear_scan();
		scan_mode = MODE_TEXT;
		oct_val = '0;
		oct_cnt = '0;
	endfunction

	// Record one decoded byte; the length counter saturates.
	function automatic void emit_decoded(logic [7:0] b);
		result_t r;
		if (unescaped_len != '1)
			unescaped_len++;
		r.out_byte = b;
		r.byte_valid = 1'b1;
		r.end_of_string = 1'b0;
		r.total_length = unescaped_len[TOTAL_W-1:0];
		step_res.push_back(r);
	endfunction

	function automatic void text_byte(logic [7:0] b);
		if (b == CH_BSLASH)
			scan_mode = MODE_ESC;
		else
			emit_decoded(b);
	endfunction

	// Work out the results of one accepted input byte and queue them.
	function automatic void predict_unescape(logic [7:0] b, logic last);
		result_t r;
		step_res = {};
		case (scan_mode)
			MODE_ESC: begin
				scan_mode = MODE_TEXT;
				if (b == CH_N) begin
					emit_decoded(CODE_LF);
				end else if (b == CH_R) begin
					emit_decoded(CODE_CR);
				end else if (b == CH_T) begin
					emit_decoded(CODE_TAB);
				end else if (is_octal(b)) begin
					scan_mode = MODE_OCT;
					oct_val = b - CH_ZERO;
					oct_cnt = 2'd1;
				end else begin
					emit_decoded(b);
				end
			end
			MODE_OCT: begin
				if (is_octal(b)) begin
					oct_val = (oct_val << 3) + (b - CH_ZERO);
					oct_cnt = oct_cnt + 2'd1;
					if (oct_cnt == 2'(OCT_MAX_DIGITS)) begin
						emit_decoded(oct_val);
						clear_scan();
					end
				end else begin
					// A non-octal byte flushes the pending value first.
					emit_decoded(oct_val);
					clear_scan();
					text_byte(b);
				end
			end
			default: begin
				scan_mode = MODE_TEXT;
				text_byte(b);
			end
		endcase

		if (last) begin
			if (scan_mode == MODE_OCT)
				emit_decoded(oct_val);
			if (step_res.size() == 0) begin
				r.out_byte = '0;
				r.byte_valid = 1'b0;
				r.end_of_string = 1'b0;
				r.total_length = unescaped_len[TOTAL_W-1:0];
				step_res.push_back(r);
			end
			r = step_res[step_res.size()-1];
			r.end_of_string = 1'b1;
			step_res[step_res.size()-1] = r;
			clear_scan();
			unescaped_len = '0;
		end

		foreach (step_res[i])
			decoded_q.push_back(step_res[i]);
	endfunction

	function automatic void report_mismatch(string field, int unsigned exp_v,
			int unsigned act_v);
		fail_cnt++;
		if (fail_cnt <= MAX_REPORTS)
			$error("%s mismatch: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
	endfunction

	// Check each egress transaction, then predict each ingress transaction.
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (decoded_q.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= MAX_REPORTS)
						$error("unexpected result: out_byte 0x%0h end_of_string %0b",
							out_ch.out_byte, out_ch.end_of_string);
				end else begin
					exp_r = decoded_q.pop_front();
					if (out_ch.out_byte !== exp_r.out_byte)
						report_mismatch("out_byte", exp_r.out_byte, out_ch.out_byte);
					if (out_ch.byte_valid !== exp_r.byte_valid)
						report_mismatch("byte_valid", exp_r.byte_valid, out_ch.byte_valid);
					if (out_ch.end_of_string !== exp_r.end_of_string)
						report_mismatch("end_of_string", exp_r.end_of_string,
							out_ch.end_of_string);
					if (out_ch.total_length !== exp_r.total_length)
						report_mismatch("total_length", exp_r.total_length,
							out_ch.total_length);
				end
			end
			if (in_ch.valid && in_ch.ready)
				predict_unescape(in_ch.in_byte, in_ch.is_last);
		end
	end

	// Offer one byte and wait until the block takes it.
	task automatic send_byte(input logic [7:0] b, input logic last);
		if (src_idle_on && $urandom_range(0, 4) == 0) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(0, 10)) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= b;
		in_ch.is_last <= last;
		do
			@(posedge clk);
		while (!in_ch.ready);
		bytes_sent++;
	endtask

	task automatic send_seq(input logic [7:0] seq[$]);
		foreach (seq[i])
			send_byte(seq[i], i == seq.size() - 1);
	endtask

	task automatic send_text(input string s);
		logic [7:0] seq[$];
		for (int i = 0; i < s.len(); i++)
			seq.push_back(s[i]);
		send_seq(seq);
	endtask

	// Stop offering bytes and hold until every expected result has come.
	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_byte_extremes();
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h7F, 1'b1);
		send_byte(8'h80, 1'b1);
		drain();
	endtask

	task automatic test_named_escapes();
		send_text("\\\\\\\"\\n\\r\\t");
		drain();
	endtask

	task automatic test_octal_escapes();
		// Three digits emit at once; three sevens overflow and are truncated.
		send_text("\\101\\777\\18");
		// A flush followed by a backslash that opens a new escape.
		send_text("\\12\\n");
		drain();
	endtask

	task automatic test_string_end();
		// Trailing backslash leaves only a bare end marker.
		send_text("x\\");
		send_text("\\");
		// Octal value still pending when the string ends.
		send_text("\\6");
		// Flush and the closing text byte in one transaction.
		send_text("\\12z");
		drain();
	endtask

	// Mostly well-formed strings with random content, some pure noise.
	task automatic send_random_string(input int n_tokens);
		logic [7:0] seq[$];
		int kind;
		int n_dig;
		logic [7:0] b;
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 10))
				seq.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat (n_tokens) begin
				kind = $urandom_range(0, 9);
				b = 8'($urandom_range(0, 255));
				case (kind)
					0, 1, 2, 3: begin
						if (b == CH_BSLASH)
							seq.push_back(CH_BSLASH);
						seq.push_back(b);
					end
					4: begin
						seq.push_back(CH_BSLASH);
						case ($urandom_range(0, 4))
							0: seq.push_back(CH_BSLASH);
							1: seq.push_back(CH_QUOTE);
							2: seq.push_back(CH_N);
							3: seq.push_back(CH_R);
							default: seq.push_back(CH_T);
						endcase
					end
					5, 6: begin
						seq.push_back(CH_BSLASH);
						n_dig = $urandom_range(1, 3);
						repeat (n_dig)
							seq.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
						if (n_dig < 3 && $urandom_range(0, 2) == 0)
							seq.push_back(CH_EIGHT + 8'($urandom_range(0, 1)));
					end
					7: begin
						seq.push_back(CH_BSLASH);
						seq.push_back(b);
					end
					8: begin
						seq.push_back(b);
					end
					default: begin
						seq.push_back(CH_BSLASH);
						repeat (3)
							seq.push_back(CH_SEVEN);
					end
				endcase
			end
			if ($urandom_range(0, 7) == 0)
				seq.push_back(CH_BSLASH);
		end
		send_seq(seq);
	endtask

	task automatic test_random_strings();
		int start_cnt;
		start_cnt = bytes_sent;
		while (bytes_sent - start_cnt < RANDOM_ITEMS) begin
			src_idle_on = $urandom_range(0, 3) != 0;
			sink_idle_on = $urandom_range(0, 3) != 0;
			send_random_string($urandom_range(1, 8));
			if (bytes_sent - start_cnt >= RANDOM_ITEMS / 2 &&
					bytes_sent - start_cnt < RANDOM_ITEMS / 2 + 12)
				drain();
		end
		drain();
	endtask

	// One long string sent back to back with no idling, ending in an escaped tab, then one short one.
	task automatic test_long_string();
		logic [7:0] b;
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		for (int i = 0; i < LONG_ITEMS; i++) begin
			b = 8'($urandom_range(0, 255));
			if (b == CH_BSLASH)
				b = CH_N;
			send_byte(b, 1'b0);
		end
		send_text("\\t");
		send_text("ab");
		drain();
	endtask

	// Test sequence.
	initial begin
		fail_cnt = 0;
		bytes_sent = 0;
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		in_ch.valid = 1'b0;
		in_ch.in_byte = '0;
		in_ch.is_last = 1'b0;
		clear_scan();
		unescaped_len = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_byte_extremes();
		test_named_escapes();
		test_octal_escapes();
		test_string_end();
		test_random_strings();
		test_long_string();

		repeat (20) @(posedge clk);
		if (fail_cnt == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
